// ===== src/dlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Delimited line field splitter package
// Shared constants, payload types and state encodings of the splitter.
// ----------------------------------------------------------------------------
package dlfs_pkg;

   // Bytes kept per field: one fewer than this is ever stored.
   localparam int FIELD_BYTES     = 64;
   // Upper bound on the field limit.
   localparam int MAX_FIELD_SLOTS = 16;

   localparam int LEN_W      = $clog2(FIELD_BYTES);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // The field limit register is five bits wide, so the cap never needs more.
   localparam logic [4:0] LIMIT_CAP = (MAX_FIELD_SLOTS > 31) ? 5'd31 : 5'(MAX_FIELD_SLOTS);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_TAB   = 8'h09;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FIELDS = CSR_INDEX_W'(1);

   localparam logic [7:0] DELIMITER_RESET  = 8'd61;
   localparam logic [4:0] MAX_FIELDS_RESET = 5'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] char_out;
      logic [3:0] field_index;
      logic       field_end;
      logic [4:0] field_count;
      logic       is_comment;
      logic       run_last;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'b001,
      PH_SPLIT = 3'b010,
      PH_DONE  = 3'b100
   } line_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_SUM  = 3'b100
   } seq_state_type;

endpackage

// ===== src/delimited_line_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// Delimited line field splitter
// Splits a byte stream of lines into trimmed fields and line summaries.
// ----------------------------------------------------------------------------
// The unit takes one byte per transaction and works on one transaction at a
// time. A byte that closes no field and brings no line summary is finished in
// the cycle it is accepted, so such bytes stream at one per cycle. A byte that
// closes a field holds further requests while the field, trimmed, is read
// back through the store's single read port, one byte per cycle while the
// result side does not stall, followed by the line summary when the line
// ends. A summary on its own also holds requests until it has been sent.
// Over a line each stored byte is written once and read at most once. The
// field store needs no clearing after reset, since a field is only ever read
// back over bytes it has written.
// ----------------------------------------------------------------------------
module delimited_line_field_splitter_unit
   import dlfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // Register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [7:0]     delim_ff;
   logic [4:0]     max_fields_ff;

   // Line state.
   line_phase_type phase_ff, phase_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0] trim_ff, trim_in;
   logic [4:0]     done_ff, done_in;
   logic           started_ff, started_in;

   // Sequencer and read-back state.
   seq_state_type  state_ff, state_in;
   logic [LEN_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0] emit_len_ff, emit_len_in;
   logic [3:0]     emit_idx_ff, emit_idx_in;
   logic           pend_ff, pend_in;
   logic           pend_last_ff, pend_last_in;
   logic           sum_pend_ff, sum_pend_in;
   logic [4:0]     sum_cnt_ff, sum_cnt_in;
   logic           sum_cmt_ff, sum_cmt_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   // Transaction decode results.
   logic           req_accept;
   logic           wr_en;
   logic [LEN_W-1:0] wr_addr;
   logic           do_close;
   logic [LEN_W-1:0] close_t;
   logic [3:0]     close_idx;
   logic           do_sum;
   logic           sum_cmt;
   logic [4:0]     limit;

   logic           out_free;
   logic           rd_en;
   logic [7:0]     rd_data;
   logic           load_byte;
   logic           load_sum;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // A limit of zero behaves as one; large limits saturate at the slot count.
   always_comb begin
      if (max_fields_ff == 5'd0) begin
         limit = 5'd1;
      end else if (max_fields_ff > LIMIT_CAP) begin
         limit = LIMIT_CAP;
      end else begin
         limit = max_fields_ff;
      end
   end

   // Read, modify and write back the line state for one accepted byte. At most
   // one field closes per byte, and at most one summary follows it.
   always_comb begin
      logic [7:0] b;
      logic       blank;
      logic       term;
      logic       split;
      logic       check;
      logic       end_req;

      b       = req_data.in_byte;
      blank   = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
      term    = (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
      split   = 1'b0;
      check   = 1'b0;
      end_req = 1'b0;

      phase_in   = phase_ff;
      fill_in    = fill_ff;
      trim_in    = trim_ff;
      done_in    = done_ff;
      started_in = started_ff;
      wr_en      = 1'b0;
      wr_addr    = fill_ff;
      do_close   = 1'b0;
      close_t    = '0;
      close_idx  = '0;
      do_sum     = 1'b0;
      sum_cmt    = 1'b0;

      case (phase_ff)
         PH_LEAD: begin
            if (blank) begin
               split = 1'b0;
            end else if (b == CH_HASH) begin
               do_sum   = 1'b1;
               sum_cmt  = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_SPLIT;
               split    = 1'b1;
            end
         end
         PH_SPLIT: begin
            split = 1'b1;
         end
         default: begin
            split = 1'b0;
         end
      endcase

      if (split) begin
         if (term) begin
            end_req = 1'b1;
         end else if ((b == delim_ff) && (fill_ff != '0)) begin
            do_close   = 1'b1;
            close_t    = trim_in;
            close_idx  = done_in[3:0];
            done_in    = done_in + 5'd1;
            fill_in    = '0;
            trim_in    = '0;
            started_in = 1'b0;
            check      = 1'b1;
         end else if (!started_ff && blank) begin
            check = 1'b0;
         end else begin
            started_in = 1'b1;
            check      = 1'b1;
            if (fill_ff < LEN_W'(FIELD_BYTES - 1)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + LEN_W'(1);
               if (b != CH_SPACE) begin
                  trim_in = fill_in;
               end
            end
         end
         if (check && (done_in >= limit)) begin
            end_req = 1'b1;
         end
      end

      // The buffer end closes a line that is still open.
      if (req_data.end_of_buffer && (phase_in != PH_DONE) && !end_req) begin
         end_req = 1'b1;
      end

      if (end_req) begin
         if (fill_in != '0) begin
            do_close   = 1'b1;
            close_t    = trim_in;
            close_idx  = done_in[3:0];
            done_in    = done_in + 5'd1;
            fill_in    = '0;
            trim_in    = '0;
            started_in = 1'b0;
         end
         do_sum   = 1'b1;
         sum_cmt  = 1'b0;
         phase_in = PH_DONE;
      end

      sum_cnt_in = sum_cmt ? 5'd0 : done_in;
      sum_cmt_in = sum_cmt;

      if (req_data.end_of_buffer) begin
         phase_in   = PH_LEAD;
         fill_in    = '0;
         trim_in    = '0;
         done_in    = '0;
         started_in = 1'b0;
      end
   end

   dlfs_ram #(
      .WIDTH (8),
      .DEPTH (FIELD_BYTES)
   ) u_field_store (
      .clock   (clock),
      .wr_en   (req_accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.in_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // The output register can take a new result when it is empty or its
   // current result leaves in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // A read is issued only when the pending slot will be free to hold its data.
   assign rd_en     = (state_ff == ST_EMIT) && (rd_ptr_ff != emit_len_ff) &&
                      (!pend_ff || out_free);
   assign load_byte = (state_ff == ST_EMIT) && pend_ff && out_free;
   assign load_sum  = (state_ff == ST_SUM) && out_free;

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      emit_len_in  = emit_len_ff;
      emit_idx_in  = emit_idx_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      sum_pend_in  = sum_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rd_ptr_in   = '0;
               emit_len_in = close_t;
               emit_idx_in = close_idx;
               sum_pend_in = do_sum;
               if (do_close && (close_t != '0)) begin
                  state_in = ST_EMIT;
               end else if (do_sum) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_EMIT: begin
            if (load_byte) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = 1'b0;
               rsp_data_in.char_out    = rd_data;
               rsp_data_in.field_index = emit_idx_ff;
               rsp_data_in.field_end   = pend_last_ff;
               rsp_data_in.field_count = 5'd0;
               rsp_data_in.is_comment  = 1'b0;
               rsp_data_in.run_last    = pend_last_ff && !sum_pend_ff;
               pend_in                 = 1'b0;
               if (pend_last_ff) begin
                  state_in = sum_pend_ff ? ST_SUM : ST_IDLE;
               end
            end
            if (rd_en) begin
               rd_ptr_in    = rd_ptr_ff + LEN_W'(1);
               pend_in      = 1'b1;
               pend_last_in = ((rd_ptr_ff + LEN_W'(1)) == emit_len_ff);
            end
         end
         ST_SUM: begin
            if (load_sum) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = 1'b1;
               rsp_data_in.char_out    = 8'd0;
               rsp_data_in.field_index = 4'd0;
               rsp_data_in.field_end   = 1'b0;
               rsp_data_in.field_count = sum_cnt_ff;
               rsp_data_in.is_comment  = sum_cmt_ff;
               rsp_data_in.run_last    = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff      <= DELIMITER_RESET;
         max_fields_ff <= MAX_FIELDS_RESET;
         phase_ff      <= PH_LEAD;
         fill_ff       <= '0;
         trim_ff       <= '0;
         done_ff       <= '0;
         started_ff    <= 1'b0;
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DELIMITER:  delim_ff      <= csr_data;
               CSR_MAX_FIELDS: max_fields_ff <= csr_data[4:0];
               default:        delim_ff      <= delim_ff;
            endcase
         end
         if (req_accept) begin
            phase_ff   <= phase_in;
            fill_ff    <= fill_in;
            trim_ff    <= trim_in;
            done_ff    <= done_in;
            started_ff <= started_in;
         end
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      emit_len_ff  <= emit_len_in;
      emit_idx_ff  <= emit_idx_in;
      pend_last_ff <= pend_last_in;
      sum_pend_ff  <= sum_pend_in;
      rsp_data_ff  <= rsp_data_in;
      if (req_accept) begin
         sum_cnt_ff <= sum_cnt_in;
         sum_cmt_ff <= sum_cmt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Read data may only be pending while a field is being read back.
   a_pend_in_emit: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_EMIT))
      else $error("read data pending outside field read-back");

   // Reads never run past the trimmed length of the closing field.
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_ptr_ff < emit_len_ff))
      else $error("field store read beyond trimmed length");

   // The closed-field count stays within the largest limit.
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= LIMIT_CAP)
      else $error("field count exceeds the slot limit");

   // A summary is always the last result of its transaction.
   a_sum_to_idle: assert property (@(posedge clock) disable iff (reset)
      load_sum |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after line summary");

   // The buffer end returns the line state to its starting point.
   a_eob_reset: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.end_of_buffer) |=>
         ((phase_ff == PH_LEAD) && (fill_ff == '0) && (done_ff == '0)))
      else $error("line state not cleared at buffer end");

endmodule

// ===== src/dlfs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dlfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
